@@ design/alif_pkg.sv @@
package alif_pkg;

   localparam int DATA_W = 32;
   localparam int RATE_W = 16;
   localparam int STEP_W = 31;
   localparam int IDX_W  = 10;
   localparam int ADDR_W = 5;
   localparam int EXT_W  = 17;
   localparam int SUM_W  = 40;
   localparam int PART_W = 34;
   localparam int X_W    = 35;
   localparam int PROD_W = X_W + RATE_W + 1;
   localparam int Q_W    = PROD_W - RATE_W;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SUM,
      ST_XSUM,
      ST_MUL_V,
      ST_VOLT,
      ST_ADAPT,
      ST_EXC,
      ST_INH,
      ST_PUT
   } state_type;

   typedef enum logic [1:0] {
      MUL_VOLT,
      MUL_ADAPT,
      MUL_EXC,
      MUL_INH
   } mul_sel_type;

   typedef enum logic [2:0] {
      REG_REST,
      REG_THRESHOLD,
      REG_DT_OVER_CM,
      REG_ADAPT_LEAK,
      REG_ADAPT_STEP,
      REG_EXC_DECAY,
      REG_INH_DECAY,
      REG_REFRACTORY
   } reg_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] voltage;
      logic signed [DATA_W-1:0] adaptation;
      logic [DATA_W-1:0]        last_spike;
      logic signed [DATA_W-1:0] exc;
      logic signed [DATA_W-1:0] inh;
   } neuron_state_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic fits;
      fits = (&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]);
      if (fits) begin
         return v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

@@ design/alif_ram.sv @@
module alif_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/adaptive_lif_neuron_update.sv @@
// Adaptive leaky integrate-and-fire neuron update.
// Request channel (req_valid/req_stall) carries a neuron index, the time step,
// excitatory and inhibitory current increments and a drive term. Each request
// gives exactly one response (rsp_valid/rsp_stall): neuron id, spike flag, new
// voltage and new adaptation current. An index at or above NEURONS leaves the
// state alone and answers with zero spike, voltage and adaptation.
// Per-neuron state sits in one RAM, read once per request and written once per
// in-range request. The arithmetic runs through one shared 35x17 multiplier
// under a sequencer; req_stall is high while a request is in work, so the block
// takes no new request until the sequencer has handed the last one over.
// An index at or above NEURONS skips the arithmetic.
// The response sits in an output register: a stalled receiver holds it there,
// and the next request may be accepted and worked while it waits, stopping
// only at the point of handing over its own response.
// After reset the RAM is cleared one entry a cycle, all NEURONS entries, with
// req_stall high; the registers on the APB port reset to zero and may be
// written at any time. Write registers only when no request is outstanding.
module adaptive_lif_neuron_update #(
   parameter int NEURONS = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [alif_pkg::IDX_W-1:0]            req_neuron_index,
   input  logic [alif_pkg::DATA_W-1:0]           req_time_step,
   input  logic signed [alif_pkg::DATA_W-1:0]    req_exc_current_in,
   input  logic signed [alif_pkg::DATA_W-1:0]    req_inh_current_in,
   input  logic signed [alif_pkg::DATA_W-1:0]    req_drive_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [alif_pkg::IDX_W-1:0]            rsp_neuron_id,
   output logic                                  rsp_spiked,
   output logic signed [alif_pkg::DATA_W-1:0]    rsp_voltage_out,
   output logic signed [alif_pkg::DATA_W-1:0]    rsp_adaptation_out,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [alif_pkg::ADDR_W-1:0]           paddr,
   input  logic [alif_pkg::DATA_W-1:0]           pwdata,
   output logic [alif_pkg::DATA_W-1:0]           prdata,
   output logic                                  pready
);

   import alif_pkg::*;

   localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;

   // configuration
   logic signed [DATA_W-1:0] rest_ff, thr_ff;
   logic [RATE_W-1:0]        dt_ff, alr_ff, erate_ff, irate_ff, refr_ff;
   logic [STEP_W-1:0]        step_ff;
   logic                     cfg_wr;
   reg_index_type            cfg_idx;

   // control
   state_type   state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic        ram_we, ram_re, mul_en, out_free, rsp_load, accept;
   mul_sel_type mul_sel;

   // request
   logic [IDX_W-1:0]         idx_ff;
   logic [DATA_W-1:0]        t_ff;
   logic signed [DATA_W-1:0] de_ff, di_ff, drive_ff;
   logic                     in_range_ff;
   logic [EXT_W-1:0]         idx_ext;
   logic [AW-1:0]            idx_addr;

   // datapath
   neuron_state_type         rd_state, wr_state;
   logic signed [DATA_W-1:0] v_ff, w_ff, ie_ff, ii_ff, vn_ff, wn_ff, ien_ff;
   logic [DATA_W-1:0]        lst_ff;
   logic                     online_ff, spk_ff;
   logic signed [PART_W-1:0] pa_ff, pb_ff, wp_ff;
   logic signed [X_W-1:0]    x_ff, op_a;
   logic [RATE_W-1:0]        op_r;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [Q_W-1:0]    q;
   logic signed [DATA_W-1:0] vn_in, wn_in, ien_in, iin_in;

   // response
   logic                     rsp_valid_ff, rsp_spiked_ff;
   logic [IDX_W-1:0]         rsp_id_ff;
   logic signed [DATA_W-1:0] rsp_volt_ff, rsp_adapt_ff;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign cfg_idx = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff  <= '0;
         thr_ff   <= '0;
         dt_ff    <= '0;
         alr_ff   <= '0;
         step_ff  <= '0;
         erate_ff <= '0;
         irate_ff <= '0;
         refr_ff  <= '0;
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_REST:       rest_ff  <= pwdata;
            REG_THRESHOLD:  thr_ff   <= pwdata;
            REG_DT_OVER_CM: dt_ff    <= pwdata[RATE_W-1:0];
            REG_ADAPT_LEAK: alr_ff   <= pwdata[RATE_W-1:0];
            REG_ADAPT_STEP: step_ff  <= pwdata[STEP_W-1:0];
            REG_EXC_DECAY:  erate_ff <= pwdata[RATE_W-1:0];
            REG_INH_DECAY:  irate_ff <= pwdata[RATE_W-1:0];
            REG_REFRACTORY: refr_ff  <= pwdata[RATE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (cfg_idx)
         REG_REST:       prdata = rest_ff;
         REG_THRESHOLD:  prdata = thr_ff;
         REG_DT_OVER_CM: prdata = DATA_W'(dt_ff);
         REG_ADAPT_LEAK: prdata = DATA_W'(alr_ff);
         REG_ADAPT_STEP: prdata = DATA_W'(step_ff);
         REG_EXC_DECAY:  prdata = DATA_W'(erate_ff);
         REG_INH_DECAY:  prdata = DATA_W'(irate_ff);
         REG_REFRACTORY: prdata = DATA_W'(refr_ff);
      endcase
   end

   // ---------------- sequencer ----------------
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(NEURONS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ:  state_in = in_range_ff ? ST_LOAD : ST_PUT;
         ST_LOAD:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_XSUM;
         ST_XSUM:  state_in = ST_MUL_V;
         ST_MUL_V: state_in = ST_VOLT;
         ST_VOLT:  state_in = ST_ADAPT;
         ST_ADAPT: state_in = ST_EXC;
         ST_EXC:   state_in = ST_INH;
         ST_INH:   state_in = ST_PUT;
         ST_PUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      mul_en    = 1'b0;
      mul_sel   = MUL_VOLT;
      rsp_load  = 1'b0;
      clr_in    = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE:  req_stall = 1'b0;
         ST_READ:  ram_re = 1'b1;
         ST_MUL_V: begin
            mul_en  = 1'b1;
            mul_sel = MUL_VOLT;
         end
         ST_VOLT: begin
            mul_en  = 1'b1;
            mul_sel = MUL_ADAPT;
         end
         ST_ADAPT: begin
            mul_en  = 1'b1;
            mul_sel = MUL_EXC;
         end
         ST_EXC: begin
            mul_en  = 1'b1;
            mul_sel = MUL_INH;
         end
         ST_INH:   ram_we = 1'b1;
         ST_PUT:   rsp_load = out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // ---------------- state memory ----------------
   assign idx_ext  = EXT_W'(idx_ff);
   assign idx_addr = idx_ext[AW-1:0];

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_state = '0;
      end else begin
         wr_state.voltage    = vn_ff;
         wr_state.adaptation = wn_ff;
         wr_state.last_spike = spk_ff ? t_ff : lst_ff;
         wr_state.exc        = ien_ff;
         wr_state.inh        = iin_in;
      end
   end

   alif_ram #(
      .WIDTH ($bits(neuron_state_type)),
      .DEPTH (NEURONS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ((state_ff == ST_CLEAR) ? clr_ff : idx_addr),
      .wr_data (wr_state),
      .rd_en   (ram_re),
      .rd_addr (idx_addr),
      .rd_data (rd_state)
   );

   // ---------------- shared multiplier ----------------
   always_comb begin
      unique case (mul_sel)
         MUL_VOLT: begin
            op_a = x_ff;
            op_r = dt_ff;
         end
         MUL_ADAPT: begin
            op_a = X_W'(w_ff);
            op_r = alr_ff;
         end
         MUL_EXC: begin
            op_a = X_W'(ie_ff);
            op_r = erate_ff;
         end
         MUL_INH: begin
            op_a = X_W'(ii_ff);
            op_r = irate_ff;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'($signed({1'b0, op_r}));
   // arithmetic shift floors, matching rounding toward minus infinity
   assign q       = $signed(prod_ff[PROD_W-1:RATE_W]);

   assign vn_in  = online_ff ? sat32(SUM_W'(v_ff) + SUM_W'(q)) : v_ff;
   assign wn_in  = sat32(SUM_W'(wp_ff) +
                         (spk_ff ? $signed(SUM_W'(step_ff)) : SUM_W'(0)));
   assign ien_in = sat32(SUM_W'(ie_ff) - SUM_W'(q));
   assign iin_in = sat32(SUM_W'(ii_ff) - SUM_W'(q));

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff      <= req_neuron_index;
         t_ff        <= req_time_step;
         de_ff       <= req_exc_current_in;
         di_ff       <= req_inh_current_in;
         drive_ff    <= req_drive_in;
         in_range_ff <= EXT_W'(req_neuron_index) < EXT_W'(NEURONS);
      end
      if (state_ff == ST_LOAD) begin
         v_ff      <= rd_state.voltage;
         w_ff      <= rd_state.adaptation;
         lst_ff    <= rd_state.last_spike;
         ie_ff     <= sat32(SUM_W'(rd_state.exc) + SUM_W'(de_ff));
         ii_ff     <= sat32(SUM_W'(rd_state.inh) + SUM_W'(di_ff));
         online_ff <= {1'b0, t_ff} > ({1'b0, rd_state.last_spike} + (DATA_W + 1)'(refr_ff));
      end
      if (state_ff == ST_SUM) begin
         pa_ff <= PART_W'(rest_ff) - PART_W'(v_ff) + PART_W'(drive_ff);
         pb_ff <= PART_W'(ie_ff) - PART_W'(ii_ff) - PART_W'(w_ff);
      end
      if (state_ff == ST_XSUM) begin
         x_ff <= X_W'(pa_ff) + X_W'(pb_ff);
      end
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_VOLT) begin
         vn_ff <= vn_in;
      end
      if (state_ff == ST_ADAPT) begin
         spk_ff <= vn_ff > thr_ff;
         wp_ff  <= PART_W'(w_ff) - PART_W'(q);
      end
      if (state_ff == ST_EXC) begin
         wn_ff  <= wn_in;
         ien_ff <= ien_in;
      end
   end

   // ---------------- response register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_id_ff     <= idx_ff;
         rsp_spiked_ff <= in_range_ff && spk_ff;
         rsp_volt_ff   <= in_range_ff ? vn_ff : '0;
         rsp_adapt_ff  <= in_range_ff ? wn_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neuron_id      = rsp_id_ff;
   assign rsp_spiked         = rsp_spiked_ff;
   assign rsp_voltage_out    = rsp_volt_ff;
   assign rsp_adaptation_out = rsp_adapt_ff;

   // ---------------- assertions ----------------
   a_spike_above_threshold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_spiked) |-> (rsp_voltage_out > thr_ff))
      else $error("spike reported with voltage not above threshold");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (EXT_W'(rsp_neuron_id) >= EXT_W'(NEURONS)))
      |-> (!rsp_spiked && rsp_voltage_out == '0 && rsp_adaptation_out == '0))
      else $error("out-of-range request gave a non-zero response");

   a_no_write_out_of_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_CLEAR) || in_range_ff))
      else $error("state written for an out-of-range neuron");

   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == ST_CLEAR) |-> ($past(clr_ff) == AW'(NEURONS - 1)))
      else $error("clearing pass left before the last entry");

endmodule

@@ sim/tb_adaptive_lif_neuron_update.sv @@
module tb_adaptive_lif_neuron_update;

   timeunit 1ns;
   timeprecision 1ps;

   import alif_pkg::*;

   localparam int NEURON_COUNT = 1024;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 14;

   typedef struct {
      logic [IDX_W-1:0]         idx;
      logic [DATA_W-1:0]        step;
      logic signed [DATA_W-1:0] exc;
      logic signed [DATA_W-1:0] inh;
      logic signed [DATA_W-1:0] drive;
   } neuron_request_type;

   typedef struct {
      logic [IDX_W-1:0]         id;
      logic                     spiked;
      logic signed [DATA_W-1:0] volt;
      logic signed [DATA_W-1:0] adapt;
   } neuron_result_type;

   typedef enum int {
      SET_TYPICAL,
      SET_HIGH,
      SET_ZERO,
      SET_INVERTED,
      SET_SCRAMBLED
   } setting_kind_type;

   logic clock;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [IDX_W-1:0]         req_neuron_index = '0;
   logic [DATA_W-1:0]        req_time_step = '0;
   logic signed [DATA_W-1:0] req_exc_current_in = '0;
   logic signed [DATA_W-1:0] req_inh_current_in = '0;
   logic signed [DATA_W-1:0] req_drive_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [IDX_W-1:0]         rsp_neuron_id;
   logic                     rsp_spiked;
   logic signed [DATA_W-1:0] rsp_voltage_out;
   logic signed [DATA_W-1:0] rsp_adaptation_out;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [ADDR_W-1:0]        paddr = '0;
   logic [DATA_W-1:0]        pwdata = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   // neuron state and register mirror
   logic signed [DATA_W-1:0] volt_mem  [NEURON_COUNT];
   logic signed [DATA_W-1:0] adapt_mem [NEURON_COUNT];
   logic [DATA_W-1:0]        spike_mem [NEURON_COUNT];
   logic signed [DATA_W-1:0] exc_mem   [NEURON_COUNT];
   logic signed [DATA_W-1:0] inh_mem   [NEURON_COUNT];

   logic signed [DATA_W-1:0] cfg_rest = '0;
   logic signed [DATA_W-1:0] cfg_threshold = '0;
   logic [RATE_W-1:0]        cfg_dt = '0;
   logic [RATE_W-1:0]        cfg_adapt_leak = '0;
   logic [STEP_W-1:0]        cfg_adapt_step = '0;
   logic [RATE_W-1:0]        cfg_exc_decay = '0;
   logic [RATE_W-1:0]        cfg_inh_decay = '0;
   logic [RATE_W-1:0]        cfg_refractory = '0;

   neuron_request_type request_backlog[$];
   neuron_result_type  awaited_results[$];
   neuron_request_type staged;

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   logic [31:0] step_now = 32'd100;

   adaptive_lif_neuron_update #(
      .NEURONS(NEURON_COUNT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_neuron_index(req_neuron_index),
      .req_time_step(req_time_step),
      .req_exc_current_in(req_exc_current_in),
      .req_inh_current_in(req_inh_current_in),
      .req_drive_in(req_drive_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_neuron_id(rsp_neuron_id),
      .rsp_spiked(rsp_spiked),
      .rsp_voltage_out(rsp_voltage_out),
      .rsp_adaptation_out(rsp_adaptation_out),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      for (int n = 0; n < NEURON_COUNT; n++) begin
         volt_mem[n] = '0;
         adapt_mem[n] = '0;
         spike_mem[n] = '0;
         exc_mem[n] = '0;
         inh_mem[n] = '0;
      end
   end

   function automatic logic signed [DATA_W-1:0] clamp32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -longint'(64'sd2147483648)) begin
         return 32'sh8000_0000;
      end
      return v[DATA_W-1:0];
   endfunction

   // Q0.16 product, rounded toward minus infinity
   function automatic longint scale_floor(longint x, logic [RATE_W-1:0] rate);
      return (x * longint'(rate)) >>> 16;
   endfunction

   function automatic neuron_result_type advance_neuron(neuron_request_type rq);
      neuron_result_type r;
      longint ie, ii, v, w, vn, wn;
      logic online, spk;
      r.id = rq.idx;
      r.spiked = 1'b0;
      r.volt = '0;
      r.adapt = '0;
      if (rq.idx >= NEURON_COUNT) begin
         return r;
      end
      ie = clamp32(longint'(exc_mem[rq.idx]) + longint'(rq.exc));
      ii = clamp32(longint'(inh_mem[rq.idx]) + longint'(rq.inh));
      v = volt_mem[rq.idx];
      w = adapt_mem[rq.idx];
      online = {1'b0, rq.step} > ({1'b0, spike_mem[rq.idx]} + {17'b0, cfg_refractory});
      vn = v;
      if (online) begin
         vn = clamp32(v + scale_floor(longint'(cfg_rest) - v + ie - ii
                                      + longint'(rq.drive) - w, cfg_dt));
      end
      spk = vn > longint'(cfg_threshold);
      wn = clamp32(w - scale_floor(w, cfg_adapt_leak) + (spk ? longint'(cfg_adapt_step) : 0));
      volt_mem[rq.idx] = vn[DATA_W-1:0];
      adapt_mem[rq.idx] = wn[DATA_W-1:0];
      if (spk) begin
         spike_mem[rq.idx] = rq.step;
      end
      exc_mem[rq.idx] = clamp32(ie - scale_floor(ie, cfg_exc_decay));
      inh_mem[rq.idx] = clamp32(ii - scale_floor(ii, cfg_inh_decay));
      r.spiked = spk;
      r.volt = vn[DATA_W-1:0];
      r.adapt = wn[DATA_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_results.push_back(advance_neuron('{req_neuron_index, req_time_step,
               req_exc_current_in, req_inh_current_in, req_drive_in}));
         end
         if (!req_valid || !req_stall) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               staged = request_backlog.pop_front();
               req_valid <= 1'b1;
               req_neuron_index <= staged.idx;
               req_time_step <= staged.step;
               req_exc_current_in <= staged.exc;
               req_inh_current_in <= staged.inh;
               req_drive_in <= staged.drive;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      neuron_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("response for neuron %0d with none expected",
                                         rsp_neuron_id));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_neuron_id !== want.id) begin
                  report_mismatch($sformatf("neuron_id got %0d expected %0d",
                                            rsp_neuron_id, want.id));
               end
               if (rsp_spiked !== want.spiked) begin
                  report_mismatch($sformatf("neuron %0d spiked got %0b expected %0b",
                                            want.id, rsp_spiked, want.spiked));
               end
               if (rsp_voltage_out !== want.volt) begin
                  report_mismatch($sformatf("neuron %0d voltage got %h expected %h",
                                            want.id, rsp_voltage_out, want.volt));
               end
               if (rsp_adaptation_out !== want.adapt) begin
                  report_mismatch($sformatf("neuron %0d adaptation got %h expected %h",
                                            want.id, rsp_adaptation_out, want.adapt));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type r, logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (r)
         REG_REST:       cfg_rest = value;
         REG_THRESHOLD:  cfg_threshold = value;
         REG_DT_OVER_CM: cfg_dt = value[RATE_W-1:0];
         REG_ADAPT_LEAK: cfg_adapt_leak = value[RATE_W-1:0];
         REG_ADAPT_STEP: cfg_adapt_step = value[STEP_W-1:0];
         REG_EXC_DECAY:  cfg_exc_decay = value[RATE_W-1:0];
         REG_INH_DECAY:  cfg_inh_decay = value[RATE_W-1:0];
         REG_REFRACTORY: cfg_refractory = value[RATE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(setting_kind_type kind);
      logic [31:0] v [8];
      case (kind)
         SET_TYPICAL: begin
            v[REG_REST] = -int'($urandom_range(50, 80) << 16);
            v[REG_THRESHOLD] = v[REG_REST] + ($urandom_range(5, 30) << 16);
            v[REG_DT_OVER_CM] = $urandom_range(16'h0800, 16'h8000);
            v[REG_ADAPT_LEAK] = $urandom_range(0, 16'h2000);
            v[REG_ADAPT_STEP] = $urandom_range(0, 32'h0004_0000);
            v[REG_EXC_DECAY] = $urandom_range(0, 16'hFFFF);
            v[REG_INH_DECAY] = $urandom_range(0, 16'hFFFF);
            v[REG_REFRACTORY] = $urandom_range(0, 4);
         end
         SET_HIGH: begin
            v[REG_REST] = 32'h8000_0000;
            v[REG_THRESHOLD] = 32'h7FFF_FFFF;
            v[REG_DT_OVER_CM] = 32'hFFFF;
            v[REG_ADAPT_LEAK] = 32'hFFFF;
            v[REG_ADAPT_STEP] = 32'h7FFF_FFFF;
            v[REG_EXC_DECAY] = 32'hFFFF;
            v[REG_INH_DECAY] = 32'hFFFF;
            v[REG_REFRACTORY] = 32'hFFFF;
         end
         SET_INVERTED: begin
            v[REG_REST] = 32'h7FFF_FFFF;
            v[REG_THRESHOLD] = 32'h8000_0000;
            v[REG_DT_OVER_CM] = 32'hFFFF;
            v[REG_ADAPT_LEAK] = 32'hFFFF;
            v[REG_ADAPT_STEP] = 32'h7FFF_FFFF;
            v[REG_EXC_DECAY] = 32'hFFFF;
            v[REG_INH_DECAY] = 32'hFFFF;
            v[REG_REFRACTORY] = '0;
         end
         SET_SCRAMBLED: begin
            v[REG_REST] = $urandom;
            v[REG_THRESHOLD] = $urandom;
            v[REG_DT_OVER_CM] = $urandom_range(0, 16'hFFFF);
            v[REG_ADAPT_LEAK] = $urandom_range(0, 16'hFFFF);
            v[REG_ADAPT_STEP] = $urandom & 32'h7FFF_FFFF;
            v[REG_EXC_DECAY] = $urandom_range(0, 16'hFFFF);
            v[REG_INH_DECAY] = $urandom_range(0, 16'hFFFF);
            v[REG_REFRACTORY] = $urandom_range(0, 16'hFFFF);
         end
         default: begin
            for (int k = 0; k < 8; k++) v[k] = '0;
         end
      endcase
      for (int k = 0; k < 8; k++) begin
         csr_write(reg_index_type'(k), v[k]);
      end
   endtask

   task automatic queue_request(int idx, logic [31:0] step, logic [31:0] exc,
                                logic [31:0] inh, logic [31:0] drive);
      request_backlog.push_back('{idx[IDX_W-1:0], step, exc, inh, drive});
   endtask

   function automatic logic signed [31:0] near_zero(int unsigned span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - int'(span);
      return v;
   endfunction

   task automatic fill_random(int count);
      int unsigned pool [8];
      int roll;
      neuron_request_type r;
      for (int k = 0; k < 8; k++) pool[k] = $urandom_range(0, NEURON_COUNT - 1);
      if ($urandom_range(0, 1) == 0) begin
         pool[0] = 0;
         pool[7] = NEURON_COUNT - 1;
      end
      // occasionally run close to the top of the step counter
      if ($urandom_range(0, 3) == 0) step_now = 32'hFFFF_FFF0;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            r.idx = IDX_W'($urandom);
            r.step = $urandom;
            r.exc = $urandom;
            r.inh = $urandom;
            r.drive = $urandom;
         end else begin
            r.idx = IDX_W'(pool[$urandom_range(0, 7)]);
            if ($urandom_range(0, 2) == 0) step_now++;
            r.step = (roll < 25) ? $urandom : step_now;
            r.exc = $urandom_range(0, 20 << 16);
            r.inh = $urandom_range(0, 10 << 16);
            r.drive = near_zero(40 << 16) + (12 << 16);
         end
         request_backlog.push_back(r);
      end
   endtask

   task automatic wait_drained();
      while (request_backlog.size() > 0 || req_valid || awaited_results.size() > 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(int phase);
      if (phase < 3) begin
         send_idle_pct = 28;
         recv_idle_pct = 74;
      end else if (phase < 5) begin
         send_idle_pct = 74;
         recv_idle_pct = 28;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin
      setting_kind_type plan [6];
      plan = '{SET_TYPICAL, SET_HIGH, SET_TYPICAL, SET_INVERTED, SET_SCRAMBLED, SET_ZERO};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_REST, -(65 << 16));
      csr_write(REG_THRESHOLD, -(50 << 16));
      csr_write(REG_DT_OVER_CM, 32'h4000);
      csr_write(REG_ADAPT_LEAK, 32'h0800);
      csr_write(REG_ADAPT_STEP, 32'h0002_0000);
      csr_write(REG_EXC_DECAY, 32'h2000);
      csr_write(REG_INH_DECAY, 32'h1000);
      csr_write(REG_REFRACTORY, 32'd3);
      @(negedge clock);
      set_idling(0);

      // from the cleared state, refractory throughout: held voltage and a spike each step
      queue_request(0, 32'd1, 0, 0, 0);
      queue_request(0, 32'd2, 200 << 16, 0, 0);
      queue_request(0, 32'd3, 0, 0, 0);
      queue_request(0, 32'd5, 0, 0, 0);
      queue_request(0, 32'd6, 0, 0, 0);
      // saturation everywhere; spike at the last step, refractory sum past 32 bits
      queue_request(1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_request(1023, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(1023, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      // small negative sums rounding down
      queue_request(2, 32'd10, 0, 0, 32'hFFFF_FFFF);
      queue_request(2, 32'd11, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      queue_request(3, 32'd12, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(3, 32'd13, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_request(10'h2AA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
      queue_request(10'h155, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
      queue_request(512, 32'd20, 30 << 16, 5 << 16, 20 << 16);
      queue_request(512, 32'd21, 30 << 16, 5 << 16, 20 << 16);
      queue_request(512, 32'd25, 30 << 16, 5 << 16, 20 << 16);
      queue_request(512, 32'd30, 0, 80 << 16, 0);
      queue_request(1, 32'd0, 0, 0, 0);
      queue_request(1, 32'hFFFF_FFFF, 0, 0, 32'h7FFF_FFFF);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         apply_setting(plan[p]);
         @(negedge clock);
         set_idling(p + 1);
         fill_random(80);
         wait_drained();
      end

      if (awaited_results.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", awaited_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
